@@ rtl/core/tpsq_pkg.sv @@
// Shared constants and types of the touch press stability qualifier.
`timescale 1ns / 1ps

package tpsq_pkg;

  // Default geometry of the sample ring and the converter samples.
  localparam int DEPTH_LOG2_DEF  = 4;
  localparam int SAMPLE_BITS_DEF = 12;

  // Deviation limit register.
  localparam int              LIMIT_W     = 17;
  localparam logic [16:0]     LIMIT_RESET = 17'd60;

  // Status handed from the evaluation sequencer to the top level.
  typedef struct packed {
    logic done;    // one-cycle pulse: evaluation finished
    logic steady;  // summed deviation was below the limit
  } ev_status_t;

endpackage

@@ rtl/core/tpsq_ring_mem.sv @@
// Sample ring memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tpsq_ring_mem
  import tpsq_pkg::*;
#(
  parameter int DEPTH_LOG2 = DEPTH_LOG2_DEF,
  parameter int WIDTH      = 2 * SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [DEPTH_LOG2-1:0] wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic                  rd_en,
  input  logic [DEPTH_LOG2-1:0] rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/tpsq_eval.sv @@
// Evaluation sequencer: two passes over the ring for the means and the deviation sum.
`timescale 1ns / 1ps

module tpsq_eval
  import tpsq_pkg::*;
#(
  parameter int DEPTH_LOG2  = DEPTH_LOG2_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [LIMIT_W-1:0]       limit,
  output logic                     rd_en,
  output logic [DEPTH_LOG2-1:0]    rd_addr,
  input  logic [2*SAMPLE_BITS-1:0] rd_data,
  output ev_status_t               status,
  output logic [SAMPLE_BITS-1:0]   mean_x,
  output logic [SAMPLE_BITS-1:0]   mean_y
);

  localparam int DEPTH = 1 << DEPTH_LOG2;
  localparam int ROUND = DEPTH / 2;
  localparam int SUM_W = SAMPLE_BITS + DEPTH_LOG2;
  localparam int DEV_W = SAMPLE_BITS + DEPTH_LOG2 + 1;
  localparam int CMP_W = (DEV_W > LIMIT_W) ? DEV_W : LIMIT_W;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SUM  = 3'd1;
  localparam logic [2:0] PH_MEAN = 3'd2;
  localparam logic [2:0] PH_DEV  = 3'd3;
  localparam logic [2:0] PH_CMP  = 3'd4;

  logic [2:0]             phase_r;
  logic [DEPTH_LOG2-1:0]  issue_r;
  logic                   issuing_r;
  logic                   rd_vld_r;
  logic                   rd_last_r;
  logic [SUM_W-1:0]       sum_x_r;
  logic [SUM_W-1:0]       sum_y_r;
  logic [DEV_W-1:0]       dev_r;
  logic [SAMPLE_BITS-1:0] mean_x_r;
  logic [SAMPLE_BITS-1:0] mean_y_r;
  ev_status_t             status_r;

  logic [SAMPLE_BITS-1:0] smp_x;
  logic [SAMPLE_BITS-1:0] smp_y;
  logic [SAMPLE_BITS-1:0] diff_x;
  logic [SAMPLE_BITS-1:0] diff_y;
  logic [DEV_W-1:0]       dev_add;

  assign smp_x = rd_data[SAMPLE_BITS-1:0];
  assign smp_y = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // Absolute deviation of the returning pair from the latched means.
  always_comb begin
    diff_x  = (mean_x_r >= smp_x) ? (mean_x_r - smp_x) : (smp_x - mean_x_r);
    diff_y  = (mean_y_r >= smp_y) ? (mean_y_r - smp_y) : (smp_y - mean_y_r);
    dev_add = DEV_W'(diff_x) + DEV_W'(diff_y);
  end

  assign rd_en   = issuing_r;
  assign rd_addr = issue_r;
  assign status  = status_r;
  assign mean_x  = mean_x_r;
  assign mean_y  = mean_y_r;

  // Address issue, read tracking and the pass sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      issue_r   <= '0;
      issuing_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      status_r  <= '0;
    end else begin
      status_r.done <= (phase_r == PH_CMP);
      rd_vld_r      <= issuing_r;
      rd_last_r     <= issuing_r && (&issue_r);

      if (issuing_r) begin
        issue_r <= issue_r + 1'b1;
        if (&issue_r) begin
          issuing_r <= 1'b0;
        end
      end

      unique case (phase_r)
        PH_IDLE: begin
          if (start) begin
            phase_r   <= PH_SUM;
            issuing_r <= 1'b1;
            issue_r   <= '0;
            sum_x_r   <= SUM_W'(ROUND);
            sum_y_r   <= SUM_W'(ROUND);
          end
        end
        PH_SUM: begin
          if (rd_vld_r) begin
            sum_x_r <= sum_x_r + SUM_W'(smp_x);
            sum_y_r <= sum_y_r + SUM_W'(smp_y);
          end
          if (rd_last_r) begin
            phase_r <= PH_MEAN;
          end
        end
        PH_MEAN: begin
          // Rounded mean: the sum already carries half a step.
          mean_x_r  <= sum_x_r[SUM_W-1:DEPTH_LOG2];
          mean_y_r  <= sum_y_r[SUM_W-1:DEPTH_LOG2];
          dev_r     <= '0;
          issuing_r <= 1'b1;
          issue_r   <= '0;
          phase_r   <= PH_DEV;
        end
        PH_DEV: begin
          if (rd_vld_r) begin
            dev_r <= dev_r + dev_add;
          end
          if (rd_last_r) begin
            phase_r <= PH_CMP;
          end
        end
        PH_CMP: begin
          status_r.steady <= CMP_W'(dev_r) < CMP_W'(limit);
          phase_r         <= PH_IDLE;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/touch_press_stability_qualifier.sv @@
// Top level of the touch press stability qualifier.
`timescale 1ns / 1ps

// Usage
// Each request on the in_ stream is one panel tick: pressed flag and an X/Y sample
// pair. Every request yields exactly one result on the out_ stream carrying the
// done_res and beep pulses and the latest rounded means pos_x and pos_y.
// The cfg_ channel writes the deviation limit (reset value 60); it is always ready
// and should only be written while no request is outstanding.
// A tick that needs no evaluation has its result registered at the edge that accepts
// it, so the result is offered from the next cycle and such requests can follow back
// to back. A pressed tick with a full ring and an unconfirmed touch starts two passes
// over the ring memory (one read a cycle): its result is registered after the sum
// pass, the mean step, the deviation pass and the compare step, and the next request
// is taken in the cycle after that result is registered. The memory read port, one
// entry per cycle, sets the length of the passes.
// Reset (synchronous, rst_n low) clears the touch state and the means and loads the
// limit with 60; the ring holds no valid data and is only read after a full refill.
// When the receiver stalls, the result stays in the output register and no new
// request is taken until that register is free or being emptied.

module touch_press_stability_qualifier
  import tpsq_pkg::*;
#(
  parameter int DEPTH_LOG2  = DEPTH_LOG2_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_BITS    = 1 + 2 * SAMPLE_BITS,
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 2 + 2 * SAMPLE_BITS,
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // pressed, sample_x, sample_y (from bit 0 up), zero padded
  input  logic [IN_W-1:0]    in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // done_res, beep, pos_x, pos_y (from bit 0 up), zero padded
  output logic [OUT_W-1:0]   out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]             state_r;
  logic [LIMIT_W-1:0]     limit_r;
  logic [DEPTH_LOG2-1:0]  write_index_r;
  logic                   ring_full_r;
  logic                   touch_held_r;
  logic                   touch_confirmed_r;
  logic [SAMPLE_BITS-1:0] mean_x_r;
  logic [SAMPLE_BITS-1:0] mean_y_r;
  logic                   out_tvalid_r;
  logic [OUT_W-1:0]       out_tdata_r;
  logic [OUT_W-1:0]       out_tdata_nxt;

  logic                   in_pressed;
  logic [SAMPLE_BITS-1:0] in_x;
  logic [SAMPLE_BITS-1:0] in_y;
  logic                   out_free;
  logic                   accept;
  logic                   new_press;
  logic [DEPTH_LOG2-1:0]  wr_addr;
  logic [DEPTH_LOG2-1:0]  wr_idx_inc;
  logic                   full_nxt;
  logic                   do_eval;
  logic                   ev_start;
  logic                   out_load;
  logic                   out_done;
  logic                   out_beep;

  logic                     rd_en;
  logic [DEPTH_LOG2-1:0]    rd_addr;
  logic [2*SAMPLE_BITS-1:0] rd_data;
  ev_status_t               ev_status;
  logic [SAMPLE_BITS-1:0]   ev_mean_x;
  logic [SAMPLE_BITS-1:0]   ev_mean_y;

  // Request fields.
  assign in_pressed = in_tdata[0];
  assign in_x       = in_tdata[SAMPLE_BITS:1];
  assign in_y       = in_tdata[2*SAMPLE_BITS:SAMPLE_BITS+1];

  // Handshakes: a request is taken only when its result can be registered.
  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) && out_free;
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Ring write position; a new press restarts the ring.
  always_comb begin
    new_press  = in_pressed && !touch_held_r;
    wr_addr    = new_press ? '0 : write_index_r;
    wr_idx_inc = wr_addr + 1'b1;
    full_nxt   = (!new_press && ring_full_r) || (wr_idx_inc == '0);
    do_eval    = in_pressed && full_nxt && !touch_confirmed_r;
    ev_start   = accept && do_eval;
  end

  // Result selection. Writes happen only in the accept cycle and the passes start
  // in the cycle after it, so reads never overlap a write of the same entry.
  always_comb begin
    out_load = 1'b0;
    out_done = 1'b0;
    out_beep = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        out_load = accept && !do_eval;
        out_done = !in_pressed && touch_held_r && touch_confirmed_r;
      end
      ST_PUSH: begin
        out_load = out_free;
        out_beep = touch_confirmed_r;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
    out_tdata_nxt = '0;
    out_tdata_nxt[0] = out_done;
    out_tdata_nxt[1] = out_beep;
    out_tdata_nxt[SAMPLE_BITS+1:2] = mean_x_r;
    out_tdata_nxt[2*SAMPLE_BITS+1:SAMPLE_BITS+2] = mean_y_r;
  end

  // Control state and the touch tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      limit_r           <= LIMIT_RESET;
      write_index_r     <= '0;
      ring_full_r       <= 1'b0;
      touch_held_r      <= 1'b0;
      touch_confirmed_r <= 1'b0;
      mean_x_r          <= '0;
      mean_y_r          <= '0;
      out_tvalid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_pressed) begin
              touch_held_r  <= 1'b1;
              write_index_r <= wr_idx_inc;
              ring_full_r   <= full_nxt;
              if (do_eval) begin
                state_r <= ST_EVAL;
              end
            end else begin
              touch_held_r      <= 1'b0;
              touch_confirmed_r <= 1'b0;
            end
          end
        end
        ST_EVAL: begin
          if (ev_status.done) begin
            mean_x_r          <= ev_mean_x;
            mean_y_r          <= ev_mean_y;
            touch_confirmed_r <= ev_status.steady;
            state_r           <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  tpsq_ring_mem #(
    .DEPTH_LOG2 (DEPTH_LOG2),
    .WIDTH      (2 * SAMPLE_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (accept && in_pressed),
    .wr_addr (wr_addr),
    .wr_data ({in_y, in_x}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tpsq_eval #(
    .DEPTH_LOG2  (DEPTH_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ev_start),
    .limit   (limit_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .status  (ev_status),
    .mean_x  (ev_mean_x),
    .mean_y  (ev_mean_y)
  );

  // A confirmed touch is always a held touch.
  a_confirmed_held: assert property (@(posedge clk) disable iff (!rst_n)
    touch_confirmed_r |-> touch_held_r)
    else $error("touch confirmed without being held");

  // An evaluation only finishes while the top level waits for it.
  a_eval_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    ev_status.done |-> (state_r == ST_EVAL))
    else $error("evaluation finished outside the wait state");

  // Starting an evaluation moves to the wait state and blocks new requests.
  a_start_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ev_start |=> (state_r == ST_EVAL) && !in_tready)
    else $error("request taken during an evaluation");

  // A result never carries both pulses.
  a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[0] && out_tdata_r[1]))
    else $error("done and beep in the same result");

endmodule
